[hdl/lphm_pkg.sv]
// Shared constants for the linear-probe hash map: hash terms, status codes and widths.
package lphm_pkg;

  localparam logic [63:0] HASH_ADD = 64'd15485863;
  localparam logic [63:0] HASH_MUL = 64'd2654435761;

  localparam logic [2:0] ST_FOUND   = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_NEW     = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_REFUSED = 3'd4;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned CNT_W = 11;

endpackage

[hdl/lphm_hash.sv]
// Start-slot hash: low index bits of (key + add) * mul, which need only low operand bits.
module lphm_hash #(
  parameter int unsigned IW = 10
) (
  input  logic [lphm_pkg::KEY_W-1:0] key_i,
  output logic [IW-1:0]              slot_o
);

  logic [IW-1:0]   sum;
  logic [2*IW-1:0] prod;

  // Reduce operands to index width before the multiply
  assign sum    = key_i[IW-1:0] + lphm_pkg::HASH_ADD[IW-1:0];
  assign prod   = sum * lphm_pkg::HASH_MUL[IW-1:0];
  assign slot_o = prod[IW-1:0];

endmodule

[hdl/linear_probe_hash_map.sv]
// Top level of the linear-probe hash map: control, slot memory and result register.
//
// Input channel: in_valid_i with operation_i, key_i, value_in_i; the block raises
// in_stall_o while it works on an item. A word is taken when valid is high and stall low.
// Output channel: out_valid_o with status_o, value_out_o, entry_count_o; the receiver
// stalls with out_stall_i, and the result word holds until taken.
// Config channel: cfg_valid_i / cfg_ready_o carry the empty marker in cfg_data_i.
// Every item gives one result. An item passes from acceptance through S_HASH, then
// S_PROBE and S_CHECK for each slot probed, to S_DONE, which loads the result register;
// each probe reads the slot memory in S_PROBE and compares in S_CHECK. A key equal to
// the marker skips probing and goes straight to S_DONE. The block takes no new item
// while it works on one. The next item is accepted once the previous
// result has been loaded into the output register, so a stalled receiver blocks
// only after one further item has finished.
// After reset every slot of the memory is swept, one slot per cycle; input
// stays stalled during the sweep while config writes are still taken.
module linear_probe_hash_map #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [lphm_pkg::KEY_W-1:0]  key_i,
  input  logic [lphm_pkg::VAL_W-1:0]  value_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [lphm_pkg::VAL_W-1:0]  value_out_o,
  output logic [lphm_pkg::CNT_W-1:0]  entry_count_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lphm_pkg::KEY_W-1:0]  cfg_data_i
);

  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned CW    = IW + 1;
  localparam int unsigned MW    = 1 + lphm_pkg::KEY_W + lphm_pkg::VAL_W;
  localparam logic [CW-1:0] LIMIT    = CW'((3 * SLOTS) / 4);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PROBE, S_CHECK, S_DONE
  } state_e;

  state_e                     state_q;
  logic [lphm_pkg::KEY_W-1:0] marker_q;
  logic [CW-1:0]              count_q;
  logic [IW-1:0]              clr_q;
  logic [IW-1:0]              slot_q;
  logic [IW-1:0]              probes_q;
  logic                       op_q;
  logic [lphm_pkg::KEY_W-1:0] key_q;
  logic [lphm_pkg::VAL_W-1:0] val_q;
  logic [2:0]                 res_status_q;
  logic [lphm_pkg::VAL_W-1:0] res_value_q;
  logic                       out_valid_q;
  logic [2:0]                 out_status_q;
  logic [lphm_pkg::VAL_W-1:0] out_value_q;
  logic [lphm_pkg::CNT_W-1:0] out_count_q;

  logic [IW-1:0] hash_slot;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [MW-1:0] mem_rdata_q;
  logic [MW-1:0] mem [SLOTS];

  logic                       rd_valid;
  logic [lphm_pkg::KEY_W-1:0] rd_key;
  logic [lphm_pkg::VAL_W-1:0] rd_val;
  logic                       out_free;

  lphm_hash #(.IW(IW)) u_hash (
    .key_i  (key_q),
    .slot_o (hash_slot)
  );

  assign rd_valid = mem_rdata_q[MW-1];
  assign rd_key   = mem_rdata_q[MW-2 -: lphm_pkg::KEY_W];
  assign rd_val   = mem_rdata_q[lphm_pkg::VAL_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  // Write the slot memory during the sweep and on insert or overwrite
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = {1'b1, key_q, val_q};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_CHECK && op_q) begin
      if (rd_valid && rd_key == key_q) begin
        mem_we = 1'b1;
      end else if (!rd_valid && count_q < LIMIT) begin
        mem_we = 1'b1;
      end
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[slot_q];
  end

  // Sweep the memory after reset, take the marker, hold the item, walk the probe chain, and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      marker_q    <= '0;
      count_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        marker_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_IDX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= operation_i;
            key_q    <= key_i;
            val_q    <= value_in_i;
            probes_q <= '0;
            res_value_q <= marker_q;
            if (key_i == marker_q) begin
              res_status_q <= lphm_pkg::ST_REFUSED;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_HASH;
            end
          end
        end
        S_HASH: begin
          slot_q  <= hash_slot;
          state_q <= S_PROBE;
        end
        S_PROBE: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          state_q <= S_DONE;
          if (rd_valid && rd_key == key_q) begin
            if (op_q) begin
              res_status_q <= lphm_pkg::ST_OVER;
            end else begin
              res_status_q <= lphm_pkg::ST_FOUND;
              res_value_q  <= rd_val;
            end
          end else if (!rd_valid) begin
            if (!op_q) begin
              res_status_q <= lphm_pkg::ST_MISS;
            end else if (count_q < LIMIT) begin
              res_status_q <= lphm_pkg::ST_NEW;
              count_q      <= count_q + 1'b1;
            end else begin
              res_status_q <= lphm_pkg::ST_REFUSED;
            end
          end else if (probes_q == LAST_IDX) begin
            // whole table walked without a hit or an empty slot
            res_status_q <= op_q ? lphm_pkg::ST_REFUSED : lphm_pkg::ST_MISS;
          end else begin
            slot_q   <= slot_q + 1'b1;
            probes_q <= probes_q + 1'b1;
            state_q  <= S_PROBE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_value_q  <= res_value_q;
            out_count_q  <= lphm_pkg::CNT_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign value_out_o   = out_value_q;
  assign entry_count_o = out_count_q;

  // Key count stays within the load limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LIMIT) else $error("key count beyond load limit");

  // A marker key is refused without probing
  a_marker_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && key_i == marker_q)
    |=> (state_q == S_DONE && res_status_q == lphm_pkg::ST_REFUSED))
    else $error("marker key not refused");

  // Memory is written only by the sweep or a checked probe
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_CHECK))
    else $error("stray memory write");

  // Count grows only on an insert
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == S_CHECK && $past(op_q)))
    else $error("count changed outside insert");

endmodule
